FILE: src/stt_pkg.sv
// Package for the source text tokenizer: token kinds, scan modes, result type.
`timescale 1ns / 1ps
package stt_pkg;

  localparam int OffsetBits   = 24;
  localparam int MantissaBits = 48;
  localparam int MaxNumberLen = 256;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_INT     = 3'd2,
    MODE_DOT     = 3'd3,
    MODE_FRAC    = 3'd4,
    MODE_OP      = 3'd5,
    MODE_COMMENT = 3'd6,
    MODE_HALT    = 3'd7
  } mode_t;

  localparam logic [4:0] TK_END = 5'd0;
  localparam logic [4:0] TK_ERROR = 5'd1;
  localparam logic [4:0] TK_NUMBER = 5'd2;
  localparam logic [4:0] TK_IDENT = 5'd3;
  localparam logic [4:0] TK_LET = 5'd4;
  localparam logic [4:0] TK_IF = 5'd5;
  localparam logic [4:0] TK_FOR = 5'd6;
  localparam logic [4:0] TK_PRINT = 5'd7;
  localparam logic [4:0] TK_PRINTLN = 5'd8;
  localparam logic [4:0] TK_TRUE = 5'd9;
  localparam logic [4:0] TK_FALSE = 5'd10;
  localparam logic [4:0] TK_LPAREN = 5'd11;
  localparam logic [4:0] TK_RPAREN = 5'd12;
  localparam logic [4:0] TK_LBRACE = 5'd13;
  localparam logic [4:0] TK_RBRACE = 5'd14;
  localparam logic [4:0] TK_COLON = 5'd15;
  localparam logic [4:0] TK_ASSIGN = 5'd16;
  localparam logic [4:0] TK_SEMI = 5'd17;
  localparam logic [4:0] TK_PLUS = 5'd18;
  localparam logic [4:0] TK_MINUS = 5'd19;
  localparam logic [4:0] TK_ARROW = 5'd20;
  localparam logic [4:0] TK_SLASH = 5'd21;
  localparam logic [4:0] TK_STAR = 5'd22;
  localparam logic [4:0] TK_POW = 5'd23;
  localparam logic [4:0] TK_EQ = 5'd24;
  localparam logic [4:0] TK_EQEQ = 5'd25;
  localparam logic [4:0] TK_GT = 5'd26;
  localparam logic [4:0] TK_LT = 5'd27;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_CHAR = 2'd1;
  localparam logic [1:0] ERR_LONG = 2'd2;

  typedef struct packed {
    logic                    last;
    logic [1:0]              err;
    logic                    sat;
    logic [7:0]              frac;
    logic [MantissaBits-1:0] man;
    logic [8:0]              len;
    logic [OffsetBits-1:0]   off;
    logic [15:0]             line;
    logic [4:0]              kind;
  } token_t;

  function automatic logic letter_code(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic digit_code(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [4:0] single_op_kind(input logic [7:0] c);
    case (c)
      8'h28: return TK_LPAREN;
      8'h29: return TK_RPAREN;
      8'h7b: return TK_LBRACE;
      8'h7d: return TK_RBRACE;
      8'h3a: return TK_COLON;
      8'h3b: return TK_SEMI;
      8'h2b: return TK_PLUS;
      8'h2d: return TK_MINUS;
      8'h2f: return TK_SLASH;
      8'h2a: return TK_STAR;
      8'h3d: return TK_EQ;
      8'h3e: return TK_GT;
      8'h3c: return TK_LT;
      default: return TK_END;
    endcase
  endfunction

  function automatic logic [4:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    if (p == 8'h3a && c == 8'h3d) return TK_ASSIGN;
    if (p == 8'h2d && c == 8'h3e) return TK_ARROW;
    if (p == 8'h2a && c == 8'h2a) return TK_POW;
    if (p == 8'h3d && c == 8'h3d) return TK_EQEQ;
    return TK_END;
  endfunction

  function automatic logic [4:0] word_kind(input logic [8:0] len, input logic [55:0] w);
    if (len == 9'd3 && w == 56'h6c6574) return TK_LET;
    if (len == 9'd2 && w == 56'h6966) return TK_IF;
    if (len == 9'd3 && w == 56'h666f72) return TK_FOR;
    if (len == 9'd5 && w == 56'h7072696e74) return TK_PRINT;
    if (len == 9'd7 && w == 56'h7072696e746c6e) return TK_PRINTLN;
    if (len == 9'd4 && w == 56'h74727565) return TK_TRUE;
    if (len == 9'd5 && w == 56'h66616c7365) return TK_FALSE;
    return TK_IDENT;
  endfunction

endpackage

FILE: src/stt_digit_acc.sv
// Saturating decimal mantissa accumulate: acc*10+d via shifts and adds.
`timescale 1ns / 1ps
module stt_digit_acc (
  input  logic [stt_pkg::MantissaBits-1:0] acc,
  input  logic                             ovf,
  input  logic [7:0]                       char_code,
  output logic [stt_pkg::MantissaBits-1:0] acc_next,
  output logic                             ovf_next
);
  localparam int W = stt_pkg::MantissaBits;
  logic [W+4:0] prod;
  logic [3:0]   d;

  always_comb begin
    d = char_code[3:0] - 4'd0;
    prod = (W+5)'({acc, 3'b000}) + (W+5)'({acc, 1'b0}) + (W+5)'(d);
    if (ovf) begin
      acc_next = acc;
      ovf_next = 1'b1;
    end else if (prod[W+4:W] != '0) begin
      acc_next = '1;
      ovf_next = 1'b1;
    end else begin
      acc_next = prod[W-1:0];
      ovf_next = 1'b0;
    end
  end
endmodule

FILE: src/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
`timescale 1ns / 1ps
// channel | dir | payload
// s_axis  | in  | tdata[7:0] char_code, tuser end_of_text
// m_axis  | out | tdata kind..err packed, tlast last_of_run
// One byte per cycle: an item is scanned in the cycle it is taken and its tokens
// (up to two) are valid the next cycle from a two-entry output queue. Input is taken
// when the queue is empty, or holds one token that leaves in the same cycle, so an
// item that makes two tokens holds off the next item while both its tokens are queued.
// A stalled m_axis stalls s_axis. rst is synchronous and clears scan state and queue.
// After an error or end token all items are taken and make nothing.
module source_text_tokenizer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] char_code
  input  logic         s_axis_tuser,  // end_of_text
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,  // kind5 line16 off24 len9 man48 frac8 sat1 err2, pad
  output logic         m_axis_tlast   // last_of_run
);
  localparam int OB = stt_pkg::OffsetBits;
  localparam int MB = stt_pkg::MantissaBits;

  stt_pkg::mode_t        mode, mode_next;
  logic [7:0]            pend_op, pend_op_next;
  logic [OB-1:0]         pos, pos_next;
  logic [15:0]           line, line_next;
  logic [OB-1:0]         tstart, tstart_next;
  logic [8:0]            tlen, tlen_next;
  logic [55:0]           wpre, wpre_next;
  logic [MB-1:0]         man, man_next;
  logic [7:0]            frac, frac_next;
  logic                  ovf, ovf_next;

  stt_pkg::token_t       q0, q1, t0, t1;
  logic [1:0]            qn;
  logic [1:0]            nt;
  logic                  acc_in, pop;

  logic [MB-1:0]         da_acc, da_out;
  logic                  da_ovf, da_ovf_out;
  logic [7:0]            c;

  stt_digit_acc u_acc (
    .acc(da_acc), .ovf(da_ovf), .char_code(c), .acc_next(da_out), .ovf_next(da_ovf_out)
  );

  assign c = s_axis_tdata;
  assign pop = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (qn == 2'd0) || (qn == 2'd1 && pop);
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = qn != 2'd0;
  assign m_axis_tlast = q0.last;
  assign m_axis_tdata = {7'd0, q0.err, q0.sat, q0.frac, q0.man, q0.len, q0.off,
                         q0.line, q0.kind};

  function automatic logic [8:0] sinc(input logic [8:0] v);
    return (v < 9'd256) ? v + 9'd1 : v;
  endfunction

  always_comb begin
    logic [4:0]      k;
    logic            flush, start, halt_after;
    stt_pkg::token_t ts;
    mode_next = mode; pend_op_next = pend_op; pos_next = pos; line_next = line;
    tstart_next = tstart; tlen_next = tlen; wpre_next = wpre; man_next = man;
    frac_next = frac; ovf_next = ovf;
    t0 = '0; t1 = '0; nt = 2'd0; ts = '0;
    da_acc = man; da_ovf = ovf;
    flush = 1'b0; start = 1'b0; halt_after = 1'b0;
    k = '0;
    if (mode != stt_pkg::MODE_HALT) begin
      if (s_axis_tuser) begin
        flush = 1'b1;
      end else begin
        pos_next = pos + OB'(1);
        unique case (mode)
          stt_pkg::MODE_WORD:
            if (stt_pkg::letter_code(c) || stt_pkg::digit_code(c)) begin
              if (tlen < 9'd7) wpre_next = {wpre[47:0], c};
              tlen_next = sinc(tlen);
            end else begin flush = 1'b1; start = 1'b1; end
          stt_pkg::MODE_INT:
            if (stt_pkg::digit_code(c)) begin
              man_next = da_out; ovf_next = da_ovf_out; tlen_next = sinc(tlen);
            end else if (c == 8'h2e) mode_next = stt_pkg::MODE_DOT;
            else begin flush = 1'b1; start = 1'b1; end
          stt_pkg::MODE_DOT:
            if (stt_pkg::digit_code(c)) begin
              tlen_next = sinc(sinc(tlen)); man_next = da_out; ovf_next = da_ovf_out;
              if (frac < 8'd255) frac_next = frac + 8'd1;
              mode_next = stt_pkg::MODE_FRAC;
            end else flush = 1'b1;
          stt_pkg::MODE_FRAC:
            if (stt_pkg::digit_code(c)) begin
              man_next = da_out; ovf_next = da_ovf_out; tlen_next = sinc(tlen);
              if (frac < 8'd255) frac_next = frac + 8'd1;
            end else begin flush = 1'b1; start = 1'b1; end
          stt_pkg::MODE_OP: begin
            k = stt_pkg::pair_kind(pend_op, c);
            if (k != stt_pkg::TK_END) begin
              t0 = '{last: 1'b0, err: stt_pkg::ERR_NONE, sat: 1'b0, frac: '0, man: '0,
                     len: 9'd2, off: tstart, line: line, kind: k};
              nt = 2'd1; mode_next = stt_pkg::MODE_IDLE;
            end else if (pend_op == 8'h2f && c == 8'h2f) mode_next = stt_pkg::MODE_COMMENT;
            else begin flush = 1'b1; start = 1'b1; end
          end
          stt_pkg::MODE_COMMENT:
            if (c == 8'h0a) begin
              if (line != 16'hffff) line_next = line + 16'd1;
              mode_next = stt_pkg::MODE_IDLE;
            end
          default: start = 1'b1;
        endcase
      end
      // finish the pending token (always goes to slot 0)
      if (flush) begin
        mode_next = stt_pkg::MODE_IDLE;
        unique case (mode)
          stt_pkg::MODE_WORD: begin
            t0 = '{last: 1'b0, err: stt_pkg::ERR_NONE, sat: 1'b0, frac: '0, man: '0,
                   len: tlen, off: tstart, line: line,
                   kind: stt_pkg::word_kind(tlen, wpre)};
            nt = 2'd1;
          end
          stt_pkg::MODE_INT, stt_pkg::MODE_FRAC, stt_pkg::MODE_DOT: begin
            if (tlen >= 9'(stt_pkg::MaxNumberLen)) begin
              t0 = '{last: 1'b0, err: stt_pkg::ERR_LONG, sat: 1'b0, frac: '0, man: '0,
                     len: tlen, off: tstart, line: line, kind: stt_pkg::TK_ERROR};
              halt_after = 1'b1;
            end else begin
              t0 = '{last: 1'b0, err: stt_pkg::ERR_NONE, sat: ovf, frac: frac, man: man,
                     len: tlen, off: tstart, line: line, kind: stt_pkg::TK_NUMBER};
              if (mode == stt_pkg::MODE_DOT) begin
                t1 = '{last: 1'b0, err: stt_pkg::ERR_CHAR, sat: 1'b0, frac: '0, man: '0,
                       len: 9'd1, off: pos - OB'(1), line: line, kind: stt_pkg::TK_ERROR};
                nt = 2'd2;
              end
              if (mode == stt_pkg::MODE_DOT) halt_after = 1'b1;
            end
            if (nt == 2'd0) nt = 2'd1;
          end
          stt_pkg::MODE_OP: begin
            t0 = '{last: 1'b0, err: stt_pkg::ERR_NONE, sat: 1'b0, frac: '0, man: '0,
                   len: 9'd1, off: tstart, line: line,
                   kind: stt_pkg::single_op_kind(pend_op)};
            nt = 2'd1;
          end
          default: ;
        endcase
        if (halt_after) begin
          mode_next = stt_pkg::MODE_HALT; start = 1'b0;
        end
        if (s_axis_tuser && !halt_after) begin
          if (nt == 2'd0) begin
            t0 = '{last: 1'b0, err: stt_pkg::ERR_NONE, sat: 1'b0, frac: '0, man: '0,
                   len: 9'd0, off: pos, line: line, kind: stt_pkg::TK_END};
            nt = 2'd1;
          end else begin
            t1 = '{last: 1'b0, err: stt_pkg::ERR_NONE, sat: 1'b0, frac: '0, man: '0,
                   len: 9'd0, off: pos, line: line, kind: stt_pkg::TK_END};
            nt = 2'd2;
          end
        end
        if (s_axis_tuser) mode_next = stt_pkg::MODE_HALT;
      end
      // begin a new token with this byte
      if (start) begin
        mode_next = stt_pkg::MODE_IDLE;
        if (c == 8'h0a) begin
          if (line != 16'hffff) line_next = line + 16'd1;
        end else if (c != 8'h20 && c != 8'h09 && c != 8'h0d) begin
          tstart_next = pos;
          tlen_next = 9'd1;
          if (stt_pkg::letter_code(c)) begin
            mode_next = stt_pkg::MODE_WORD;
            wpre_next = {48'd0, c};
          end else if (stt_pkg::digit_code(c)) begin
            mode_next = stt_pkg::MODE_INT;
            man_next = MB'(c[3:0]); frac_next = '0; ovf_next = 1'b0;
          end else if (c == 8'h2f || c == 8'h3a || c == 8'h2d || c == 8'h2a ||
                       c == 8'h3d) begin
            mode_next = stt_pkg::MODE_OP;
            pend_op_next = c;
          end else begin
            k = stt_pkg::single_op_kind(c);
            if (k != stt_pkg::TK_END) begin
              ts = '{last: 1'b0, err: stt_pkg::ERR_NONE, sat: 1'b0, frac: '0, man: '0,
                     len: 9'd1, off: pos, line: line, kind: k};
            end else begin
              ts = '{last: 1'b0, err: stt_pkg::ERR_CHAR, sat: 1'b0, frac: '0, man: '0,
                     len: 9'd1, off: pos, line: line, kind: stt_pkg::TK_ERROR};
              mode_next = stt_pkg::MODE_HALT;
            end
            // lands behind a token flushed by this same byte, if there is one
            if (nt == 2'd0) begin
              t0 = ts; nt = 2'd1;
            end else begin
              t1 = ts; nt = 2'd2;
            end
          end
        end
      end
    end
    if (nt == 2'd1) t0.last = 1'b1;
    if (nt == 2'd2) t1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qn <= 2'd0;
    end else begin
      if (acc_in) begin
        q0 <= t0; q1 <= t1;
        qn <= nt;
      end else if (pop) begin
        q0 <= q1;
        qn <= qn - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stt_pkg::MODE_IDLE; pend_op <= '0; pos <= '0; line <= 16'd1;
      tstart <= '0; tlen <= '0; wpre <= '0; man <= '0; frac <= '0; ovf <= 1'b0;
    end else if (acc_in) begin
      mode <= mode_next; pend_op <= pend_op_next; pos <= pos_next; line <= line_next;
      tstart <= tstart_next; tlen <= tlen_next; wpre <= wpre_next; man <= man_next;
      frac <= frac_next; ovf <= ovf_next;
    end
  end
endmodule
